FILE: sv/ffba_pkg.sv
// Package for the first-fit block allocator: sizes, codes and the structs
// passed between the sequencer, the block table and the top level.
// Has no dependencies; every other file refers to it by scoped names.
package ffba_pkg;

   localparam int HEAP_BYTES   = 2048;
   localparam int HEADER_BYTES = 24;
   localparam int MAX_BLOCKS   = 64;

   localparam int ADDR_W = 11;
   localparam int SIZE_W = 12;
   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int CNT_W  = IDX_W + 1;
   localparam int BUMP_W = 12;
   // Wide enough for bump offset plus header plus the largest request.
   localparam int SUM_W  = SIZE_W + 1;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NOSPACE = 2'd1,
      STATUS_BADFREE = 2'd2
   } status_type;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  idx;
      logic [ADDR_W-1:0] offset;
      logic [SIZE_W-1:0] size;
   } entry_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic             value;
   } flag_wr_type;

   typedef struct packed {
      logic              done;
      status_type        status;
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] size;
   } result_type;

endpackage

FILE: sv/ffba_table.sv
// Block table: data offset and recorded size per block in one memory with a
// registered read port, plus a free flag per block in flip-flops.
// Depends on ffba_pkg.
module ffba_table (
   input  logic                       clock,
   input  logic                       reset,
   input  ffba_pkg::entry_wr_type     entry_wr,
   input  ffba_pkg::flag_wr_type      flag_wr,
   input  logic [ffba_pkg::IDX_W-1:0] rd_idx,
   output logic [ffba_pkg::ADDR_W-1:0] rd_offset,
   output logic [ffba_pkg::SIZE_W-1:0] rd_size,
   output logic                       rd_free
);

   localparam int WORD_W = ffba_pkg::ADDR_W + ffba_pkg::SIZE_W;

   logic [WORD_W-1:0]               mem [ffba_pkg::MAX_BLOCKS];
   logic [WORD_W-1:0]               rd_word_ff;
   logic [ffba_pkg::MAX_BLOCKS-1:0] free_ff;
   logic [ffba_pkg::MAX_BLOCKS-1:0] free_in;
   logic                            rd_free_ff;

   always_ff @(posedge clock) begin
      if (entry_wr.en) begin
         mem[entry_wr.idx] <= {entry_wr.offset, entry_wr.size};
      end
      rd_word_ff <= mem[rd_idx];
   end

   always_comb begin
      free_in = free_ff;
      if (flag_wr.en) begin
         free_in[flag_wr.idx] = flag_wr.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '0;
      end else begin
         free_ff <= free_in;
      end
      rd_free_ff <= free_ff[rd_idx];
   end

   assign rd_offset = rd_word_ff[WORD_W-1:ffba_pkg::SIZE_W];
   assign rd_size   = rd_word_ff[ffba_pkg::SIZE_W-1:0];
   assign rd_free   = rd_free_ff;

endmodule

FILE: sv/ffba_seq.sv
// Sequencer of the allocator: scans the block table one entry per cycle
// through a single shared compare unit, then grants, frees or carves a block.
// Depends on ffba_pkg and drives the write ports of ffba_table.
module ffba_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_command,
   input  logic [ffba_pkg::SIZE_W-1:0] req_request_size,
   input  logic [ffba_pkg::ADDR_W-1:0] req_block_address,
   output logic [ffba_pkg::IDX_W-1:0]  rd_idx,
   input  logic [ffba_pkg::ADDR_W-1:0] rd_offset,
   input  logic [ffba_pkg::SIZE_W-1:0] rd_size,
   input  logic                        rd_free,
   output ffba_pkg::entry_wr_type      entry_wr,
   output ffba_pkg::flag_wr_type       flag_wr,
   output ffba_pkg::result_type        result
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type                   state_ff, state_in;
   ffba_pkg::command_type       cmd_ff, cmd_in;
   logic [ffba_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [ffba_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [ffba_pkg::CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic                        pend_ff, pend_in;
   logic [ffba_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [ffba_pkg::BUMP_W-1:0] bump_ff, bump_in;

   logic [ffba_pkg::SIZE_W-1:0] cmp_a;
   logic [ffba_pkg::SIZE_W-1:0] cmp_b;
   logic [ffba_pkg::SUM_W-1:0]  cmp_diff;
   logic                        cmp_ge;
   logic                        cmp_eq;
   logic                        hit;
   logic [ffba_pkg::CNT_W-1:0]  hit_idx;
   logic [ffba_pkg::SUM_W-1:0]  data_at;
   logic [ffba_pkg::SUM_W-1:0]  end_at;
   logic                        no_space;

   // Shared compare unit: size against request for an allocate, data offset
   // against the address for a free.
   always_comb begin
      if (cmd_ff == ffba_pkg::CMD_ALLOC) begin
         cmp_a = rd_size;
         cmp_b = size_ff;
      end else begin
         cmp_a = {1'b0, rd_offset};
         cmp_b = {1'b0, addr_ff};
      end
      cmp_diff = {1'b0, cmp_a} - {1'b0, cmp_b};
      cmp_ge   = !cmp_diff[ffba_pkg::SUM_W-1];
      cmp_eq   = (cmp_diff == '0);
      if (cmd_ff == ffba_pkg::CMD_ALLOC) begin
         hit = pend_ff && rd_free && cmp_ge;
      end else begin
         hit = pend_ff && !rd_free && cmp_eq;
      end
   end

   // The entry now at the compare unit was issued in the previous cycle.
   assign hit_idx = rd_idx_ff - 1'b1;

   assign data_at  = {1'b0, bump_ff} + ffba_pkg::SUM_W'(ffba_pkg::HEADER_BYTES);
   assign end_at   = data_at + {1'b0, size_ff};
   assign no_space = (count_ff >= ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS))
                  || (data_at >= ffba_pkg::SUM_W'(ffba_pkg::HEAP_BYTES))
                  || (end_at > ffba_pkg::SUM_W'(ffba_pkg::HEAP_BYTES));

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      size_in   = size_ff;
      addr_in   = addr_ff;
      rd_idx_in = rd_idx_ff;
      pend_in   = pend_ff;
      count_in  = count_ff;
      bump_in   = bump_ff;
      entry_wr  = '0;
      flag_wr   = '0;
      result    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in    = ffba_pkg::command_type'(req_command);
               size_in   = req_request_size;
               addr_in   = req_block_address;
               rd_idx_in = '0;
               pend_in   = 1'b0;
               state_in  = (count_ff == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               flag_wr.en    = 1'b1;
               flag_wr.idx   = hit_idx[ffba_pkg::IDX_W-1:0];
               flag_wr.value = (cmd_ff == ffba_pkg::CMD_FREE);
               result.done   = 1'b1;
               result.status = ffba_pkg::STATUS_OK;
               result.addr   = rd_offset;
               result.size   = rd_size;
               pend_in       = 1'b0;
               state_in      = ST_IDLE;
            end else if (rd_idx_ff < count_ff) begin
               rd_idx_in = rd_idx_ff + 1'b1;
               pend_in   = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            result.done = 1'b1;
            if (cmd_ff == ffba_pkg::CMD_FREE) begin
               result.status = ffba_pkg::STATUS_BADFREE;
               result.addr   = addr_ff;
            end else if (no_space) begin
               result.status = ffba_pkg::STATUS_NOSPACE;
            end else begin
               entry_wr.en     = 1'b1;
               entry_wr.idx    = count_ff[ffba_pkg::IDX_W-1:0];
               entry_wr.offset = data_at[ffba_pkg::ADDR_W-1:0];
               entry_wr.size   = size_ff;
               flag_wr.en      = 1'b1;
               flag_wr.idx     = count_ff[ffba_pkg::IDX_W-1:0];
               flag_wr.value   = 1'b0;
               count_in        = count_ff + 1'b1;
               bump_in         = end_at[ffba_pkg::BUMP_W-1:0];
               result.status   = ffba_pkg::STATUS_OK;
               result.addr     = data_at[ffba_pkg::ADDR_W-1:0];
               result.size     = size_ff;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         count_ff <= '0;
         bump_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         count_ff <= count_in;
         bump_ff  <= bump_in;
      end
      cmd_ff    <= cmd_in;
      size_ff   <= size_in;
      addr_ff   <= addr_in;
      rd_idx_ff <= rd_idx_in;
   end

   assign busy   = (state_ff != ST_IDLE);
   assign rd_idx = rd_idx_ff[ffba_pkg::IDX_W-1:0];

   // An accepted command always leaves the idle state.
   assert property (@(posedge clock) disable iff (reset) start && !busy |=> busy)
      else $error("accepted command did not make the sequencer busy");

   // The scan index never runs past the block count.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> rd_idx_ff <= count_ff)
      else $error("scan index ran past the block count");

   // The table never holds more blocks than it has entries.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS))
      else $error("block count exceeds table depth");

   // The bump pointer never runs past the heap.
   assert property (@(posedge clock) disable iff (reset)
      bump_ff <= ffba_pkg::BUMP_W'(ffba_pkg::HEAP_BYTES))
      else $error("bump pointer ran past the heap");

   // The block count only changes when a new block is carved.
   assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) && !$past(reset) |-> $past(entry_wr.en))
      else $error("block count changed without a table write");

endmodule

FILE: sv/first_fit_block_allocator_top.sv
// First-fit block allocator. A command is taken when start is high and busy
// is low. An allocate scans the block table in address order, one entry per
// cycle through the single table read port, and reuses the first free block
// that is large enough; otherwise it carves header plus data from the bump
// pointer. A free scans for the in-use block with that data address. The
// result shows on the rsp_ ports for exactly one cycle, marked by rsp_valid,
// in the cycle in which busy falls; the receiver cannot stall it, and a new
// command may be given in that same cycle.
// Depends on ffba_pkg, ffba_table and ffba_seq.
module first_fit_block_allocator_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_command,
   input  logic [ffba_pkg::SIZE_W-1:0] req_request_size,
   input  logic [ffba_pkg::ADDR_W-1:0] req_block_address,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [ffba_pkg::ADDR_W-1:0] rsp_data_address,
   output logic [ffba_pkg::SIZE_W-1:0] rsp_granted_size
);

   logic [ffba_pkg::IDX_W-1:0]  rd_idx;
   logic [ffba_pkg::ADDR_W-1:0] rd_offset;
   logic [ffba_pkg::SIZE_W-1:0] rd_size;
   logic                        rd_free;
   ffba_pkg::entry_wr_type      entry_wr;
   ffba_pkg::flag_wr_type       flag_wr;
   ffba_pkg::result_type        result;

   logic                        rsp_valid_ff;
   logic [1:0]                  rsp_status_ff;
   logic [ffba_pkg::ADDR_W-1:0] rsp_addr_ff;
   logic [ffba_pkg::SIZE_W-1:0] rsp_size_ff;

   ffba_table u_table (
      .clock     (clock),
      .reset     (reset),
      .entry_wr  (entry_wr),
      .flag_wr   (flag_wr),
      .rd_idx    (rd_idx),
      .rd_offset (rd_offset),
      .rd_size   (rd_size),
      .rd_free   (rd_free)
   );

   ffba_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_request_size  (req_request_size),
      .req_block_address (req_block_address),
      .rd_idx            (rd_idx),
      .rd_offset         (rd_offset),
      .rd_size           (rd_size),
      .rd_free           (rd_free),
      .entry_wr          (entry_wr),
      .flag_wr           (flag_wr),
      .result            (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= result.done;
      end
      if (result.done) begin
         rsp_status_ff <= result.status;
         rsp_addr_ff   <= result.addr;
         rsp_size_ff   <= result.size;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_data_address = rsp_addr_ff;
   assign rsp_granted_size = rsp_size_ff;

endmodule
